>>> hw/rtl/swmm_pkg.sv
// types, codes and reset constants for the sliding window min/max block
// no dependencies; imported by swmm_cell, sliding_window_min_max and tb_top

package swmm_pkg;

  localparam int READING_W = 16;
  localparam int VAL_W     = 15;
  localparam int WS_W      = 7;
  localparam int CNT_W     = 16;
  localparam int STAT_W    = 2;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 15;

  localparam logic [WS_W-1:0]      WS_RESET = 7'd8;
  localparam logic [VAL_W-1:0]     VU_RESET = 15'd19200;
  localparam logic [CNT_W-1:0]     CNT_MAX  = 16'hFFFF;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VALID_UPPER = 1'd1;

  localparam logic [STAT_W-1:0] STAT_STATS   = 2'd0;
  localparam logic [STAT_W-1:0] STAT_IGNORED = 2'd1;
  localparam logic [STAT_W-1:0] STAT_END     = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_HOLD
  } swmm_state_t;

  typedef struct packed {
    logic             vld;
    logic [VAL_W-1:0] val;
  } cell_t;

  typedef struct packed {
    logic             act;
    logic [VAL_W-1:0] lo;
    logic [VAL_W-1:0] hi;
  } tok_t;

endpackage

>>> hw/rtl/swmm_cell.sv
// one window slot: holds a reading and its valid mark, shifts to the next slot,
// and folds its reading into the min/max token passing through; uses swmm_pkg

module swmm_cell
  import swmm_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  shift,
  input  logic  clear,
  input  logic  in_win,
  input  cell_t d_in,
  output cell_t d_out,
  input  tok_t  tok_in,
  output tok_t  tok_out
);

  logic             vld_r;
  logic [VAL_W-1:0] val_r;
  logic             act_r;
  logic [VAL_W-1:0] lo_r;
  logic [VAL_W-1:0] hi_r;
  logic             use_cell;
  logic [VAL_W-1:0] lo_nxt;
  logic [VAL_W-1:0] hi_nxt;

  assign use_cell = tok_in.act && vld_r && in_win;

  always_comb begin
    lo_nxt = tok_in.lo;
    hi_nxt = tok_in.hi;
    if (use_cell && (val_r < tok_in.lo)) begin
      lo_nxt = val_r;
    end
    if (use_cell && (val_r > tok_in.hi)) begin
      hi_nxt = val_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      act_r <= 1'b0;
    end else begin
      act_r <= tok_in.act;
      if (clear) begin
        vld_r <= 1'b0;
      end else if (shift) begin
        vld_r <= d_in.vld;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      val_r <= d_in.val;
    end
    lo_r <= lo_nxt;
    hi_r <= hi_nxt;
  end

  assign d_out   = '{vld: vld_r, val: val_r};
  assign tok_out = '{act: act_r, lo: lo_r, hi: hi_r};

endmodule

>>> hw/rtl/sliding_window_min_max.sv
// sliding window min/max top level: control, counter, output register, chain of cells
// a statistics request starts a min/max token that walks the whole cell chain before the
//   result loads the output register; no new request is taken until then; ignored and end
//   requests load the output register directly, one per cycle while the output is free
// reset (synchronous, rst_n low): window empty, counter and ignored flag cleared,
//   window_size 8, valid_upper 19200; uses swmm_pkg and swmm_cell

module sliding_window_min_max
  import swmm_pkg::*;
#(
  parameter int WINDOW_MAX = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [READING_W-1:0] in_reading,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic        [STAT_W-1:0]    out_status,
  output logic        [CNT_W-1:0]     out_sample_number,
  output logic signed [READING_W-1:0] out_value,
  output logic        [VAL_W-1:0]     out_window_min,
  output logic        [VAL_W-1:0]     out_window_max,
  output logic                        out_any_ignored,
  input  logic                        cfg_we,
  input  logic        [CFG_IDX_W-1:0] cfg_index,
  input  logic        [CFG_DAT_W-1:0] cfg_data
);

  localparam int CLW = $clog2(WINDOW_MAX + 1);
  localparam int CW  = (CLW > WS_W) ? CLW : WS_W;

  swmm_state_t state_r, state_nxt;

  logic [WS_W-1:0]  ws_r;
  logic [VAL_W-1:0] vu_r;
  logic [CNT_W-1:0] cnt_r;
  logic             ign_r;

  logic             start_act_r;
  logic [VAL_W-1:0] start_val_r;

  logic [STAT_W-1:0]           pend_status_r;
  logic [CNT_W-1:0]            pend_num_r;
  logic signed [READING_W-1:0] pend_value_r;
  logic                        pend_ign_r;
  logic [VAL_W-1:0]            pend_lo_r;
  logic [VAL_W-1:0]            pend_hi_r;

  logic                        out_valid_r;
  logic [STAT_W-1:0]           out_status_r;
  logic [CNT_W-1:0]            out_num_r;
  logic signed [READING_W-1:0] out_value_r;
  logic [VAL_W-1:0]            out_lo_r;
  logic [VAL_W-1:0]            out_hi_r;
  logic                        out_ign_r;

  logic             in_fire;
  logic             term;
  logic [VAL_W-1:0] rd_pos;
  logic             rd_ok;
  logic [CNT_W-1:0] cnt_inc;
  logic             out_free;
  logic             load_out;
  logic             hold_lohi;

  logic [STAT_W-1:0]           new_status;
  logic [CNT_W-1:0]            new_num;
  logic signed [READING_W-1:0] new_value;
  logic                        new_ign;

  logic [STAT_W-1:0]           res_status;
  logic [CNT_W-1:0]            res_num;
  logic signed [READING_W-1:0] res_value;
  logic                        res_ign;
  logic [VAL_W-1:0]            res_lo;
  logic [VAL_W-1:0]            res_hi;

  logic [CW-1:0]         ws_ext;
  logic [CW-1:0]         eff;
  logic [WINDOW_MAX-1:0] win_en;
  logic [WINDOW_MAX:0]   act_vec;

  cell_t chain_d [WINDOW_MAX+1];
  tok_t  tok_c   [WINDOW_MAX+1];
  tok_t  tok_end;

  // effective window, clamped to 1..WINDOW_MAX
  assign ws_ext = CW'(ws_r);
  always_comb begin
    eff = ws_ext;
    if (ws_ext == '0) begin
      eff = {{(CW-1){1'b0}}, 1'b1};
    end else if (ws_ext > CW'(WINDOW_MAX)) begin
      eff = CW'(WINDOW_MAX);
    end
  end

  assign in_fire  = in_valid && in_ready;
  assign term     = in_reading[READING_W-1];
  assign rd_pos   = in_reading[VAL_W-1:0];
  assign rd_ok    = !term && (rd_pos != '0) && (rd_pos < vu_r);
  assign cnt_inc  = (cnt_r == CNT_MAX) ? cnt_r : cnt_r + 16'd1;
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    if (term) begin
      new_status = STAT_END;
      new_num    = '0;
      new_value  = '0;
      new_ign    = ign_r;
    end else begin
      new_status = rd_ok ? STAT_STATS : STAT_IGNORED;
      new_num    = cnt_inc;
      new_value  = in_reading;
      new_ign    = 1'b0;
    end
  end

  // cell chain
  assign chain_d[0] = '{vld: rd_ok, val: rd_pos};
  assign tok_c[0]   = '{act: start_act_r, lo: start_val_r, hi: start_val_r};
  assign tok_end    = tok_c[WINDOW_MAX];

  genvar k;
  generate
    for (k = 0; k < WINDOW_MAX; k++) begin : g_cell
      assign win_en[k]  = (CW'(k) < eff);
      assign act_vec[k] = tok_c[k].act;
      swmm_cell u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .shift   (in_fire && !term),
        .clear   (in_fire && term),
        .in_win  (win_en[k]),
        .d_in    (chain_d[k]),
        .d_out   (chain_d[k+1]),
        .tok_in  (tok_c[k]),
        .tok_out (tok_c[k+1])
      );
    end
  endgenerate
  assign act_vec[WINDOW_MAX] = tok_end.act;

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    in_ready   = 1'b0;
    load_out   = 1'b0;
    hold_lohi  = 1'b0;
    res_status = pend_status_r;
    res_num    = pend_num_r;
    res_value  = pend_value_r;
    res_ign    = pend_ign_r;
    res_lo     = pend_lo_r;
    res_hi     = pend_hi_r;
    case (state_r)
      ST_IDLE: begin
        in_ready   = rst_n;
        res_status = new_status;
        res_num    = new_num;
        res_value  = new_value;
        res_ign    = new_ign;
        res_lo     = '0;
        res_hi     = '0;
        if (in_valid) begin
          if (rd_ok) begin
            state_nxt = ST_SWEEP;
          end else if (out_free) begin
            load_out = 1'b1;
          end else begin
            state_nxt = ST_HOLD;
          end
        end
      end
      ST_SWEEP: begin
        res_lo = tok_end.lo;
        res_hi = tok_end.hi;
        if (tok_end.act) begin
          hold_lohi = 1'b1;
          if (out_free) begin
            load_out  = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_HOLD;
          end
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // configuration, counter, flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ws_r        <= WS_RESET;
      vu_r        <= VU_RESET;
      cnt_r       <= '0;
      ign_r       <= 1'b0;
      start_act_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we && (cfg_index == CFG_WINDOW_SIZE)) begin
        ws_r <= cfg_data[WS_W-1:0];
      end
      if (cfg_we && (cfg_index == CFG_VALID_UPPER)) begin
        vu_r <= cfg_data[VAL_W-1:0];
      end
      if (in_fire) begin
        if (term) begin
          cnt_r <= '0;
          ign_r <= 1'b0;
        end else begin
          cnt_r <= cnt_inc;
          if (!rd_ok) begin
            ign_r <= 1'b1;
          end
        end
      end
      start_act_r <= in_fire && rd_ok;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    start_val_r <= rd_pos;
    if (in_fire) begin
      pend_status_r <= new_status;
      pend_num_r    <= new_num;
      pend_value_r  <= new_value;
      pend_ign_r    <= new_ign;
      pend_lo_r     <= '0;
      pend_hi_r     <= '0;
    end else if (hold_lohi) begin
      pend_lo_r <= tok_end.lo;
      pend_hi_r <= tok_end.hi;
    end
    if (load_out) begin
      out_status_r <= res_status;
      out_num_r    <= res_num;
      out_value_r  <= res_value;
      out_ign_r    <= res_ign;
      out_lo_r     <= res_lo;
      out_hi_r     <= res_hi;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_sample_number = out_num_r;
  assign out_value         = out_value_r;
  assign out_window_min    = out_lo_r;
  assign out_window_max    = out_hi_r;
  assign out_any_ignored   = out_ign_r;

  // checks
  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(act_vec))
    else $error("more than one min/max token in the chain");

  a_token_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    (act_vec != '0) |-> (state_r == ST_SWEEP))
    else $error("token moving outside of a sweep");

  a_stats_starts_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && rd_ok) |=> (state_r == ST_SWEEP) && start_act_r)
    else $error("valid request did not start a sweep");

  a_term_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && term) |=> (cnt_r == '0) && !ign_r && (chain_d[1].vld == 1'b0))
    else $error("end request did not clear the stream");

  a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r == STAT_STATS)) |-> (out_lo_r <= out_hi_r))
    else $error("window min above window max");

endmodule

>>> dv/tb_top.sv
// testbench for sliding_window_min_max: directed and random reading streams,
// window size and limit changes, back pressure
// depends on swmm_pkg and sliding_window_min_max from hw/rtl
`timescale 1ns / 100ps

module tb_top;
  import swmm_pkg::*;

  localparam int WIN_DEPTH    = 64;
  localparam int STALL_LIMIT  = 3000;
  localparam int LONG_HOLD    = 400;
  localparam int RANDOM_ITEMS = 760;
  localparam int QUIET_TAIL   = 300;

  typedef struct packed {
    logic [STAT_W-1:0]    status;
    logic [CNT_W-1:0]     sample_number;
    logic [READING_W-1:0] value;
    logic [VAL_W-1:0]     window_min;
    logic [VAL_W-1:0]     window_max;
    logic                 any_ignored;
  } min_max_result_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic signed [READING_W-1:0] in_reading = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic        [STAT_W-1:0]    out_status;
  logic        [CNT_W-1:0]     out_sample_number;
  logic signed [READING_W-1:0] out_value;
  logic        [VAL_W-1:0]     out_window_min;
  logic        [VAL_W-1:0]     out_window_max;
  logic                        out_any_ignored;
  logic                        cfg_we = 1'b0;
  logic        [CFG_IDX_W-1:0] cfg_index = '0;
  logic        [CFG_DAT_W-1:0] cfg_data = '0;

  // predictor state
  logic [VAL_W-1:0] win_cell [WIN_DEPTH];
  logic             win_ok   [WIN_DEPTH];
  logic [CNT_W-1:0] seen_count;
  logic             seen_ignored;
  logic [WS_W-1:0]  cur_wsize;
  logic [VAL_W-1:0] cur_upper;

  min_max_result_t min_max_queue[$];
  int              mismatches = 0;
  bit              tx_idle_en = 1'b1;
  bit              rx_idle_en = 1'b1;
  bit              hold_toggle = 1'b0;
  bit              hold_seen = 1'b0;

  sliding_window_min_max #(
    .WINDOW_MAX(WIN_DEPTH)
  ) i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_reading        (in_reading),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_sample_number (out_sample_number),
    .out_value         (out_value),
    .out_window_min    (out_window_min),
    .out_window_max    (out_window_max),
    .out_any_ignored   (out_any_ignored),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always #6 clk = ~clk;

  function automatic void clear_window();
    foreach (win_cell[i]) begin
      win_cell[i] = '0;
      win_ok[i]   = 1'b0;
    end
    seen_count   = '0;
    seen_ignored = 1'b0;
  endfunction

  function automatic min_max_result_t predict_min_max(input logic signed [READING_W-1:0] rd);
    min_max_result_t r;
    int              span;
    int              k;
    logic            ok;
    logic [VAL_W-1:0] lo;
    logic [VAL_W-1:0] hi;
    r = '0;
    if (rd < 0) begin
      r.status      = STAT_END;
      r.any_ignored = seen_ignored;
      clear_window();
      return r;
    end
    if (seen_count != CNT_MAX) seen_count = seen_count + 1'b1;
    ok = (rd != 0) && (rd[VAL_W-1:0] < cur_upper);
    for (k = WIN_DEPTH - 1; k > 0; k--) begin
      win_cell[k] = win_cell[k-1];
      win_ok[k]   = win_ok[k-1];
    end
    win_cell[0] = rd[VAL_W-1:0];
    win_ok[0]   = ok;
    r.sample_number = seen_count;
    r.value         = rd;
    if (!ok) begin
      seen_ignored = 1'b1;
      r.status     = STAT_IGNORED;
      return r;
    end
    span = (cur_wsize == 0) ? 1 : ((cur_wsize > WIN_DEPTH) ? WIN_DEPTH : int'(cur_wsize));
    lo = rd[VAL_W-1:0];
    hi = rd[VAL_W-1:0];
    for (k = 1; k < span; k++) begin
      if (win_ok[k]) begin
        if (win_cell[k] < lo) lo = win_cell[k];
        if (win_cell[k] > hi) hi = win_cell[k];
      end
    end
    r.status     = STAT_STATS;
    r.window_min = lo;
    r.window_max = hi;
    return r;
  endfunction

  // mostly in-range readings at the current limit, plus zeros, over-limit and noise
  function automatic logic signed [READING_W-1:0] random_reading();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 75 && cur_upper > 1)
      return READING_W'($urandom_range(1, int'(cur_upper) - 1));
    if (pick < 85) return '0;
    if (pick < 95) return READING_W'($urandom_range(int'(cur_upper), 32767));
    return READING_W'($urandom_range(0, 32767));
  endfunction

  function automatic logic signed [READING_W-1:0] random_terminator();
    return READING_W'($urandom_range(0, 32767) | 32'h8000);
  endfunction

  task automatic set_idling(input bit on);
    tx_idle_en = on;
    rx_idle_en = on;
  endtask

  task automatic send_reading(input logic signed [READING_W-1:0] rd);
    int gap;
    gap = 0;
    if (tx_idle_en && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_reading <= rd;
    do @(posedge clk); while (!in_ready);
    min_max_queue.push_back(predict_min_max(rd));
  endtask

  // drop valid, let every pending result come back, then let the chain go quiet
  task automatic settle_block();
    in_valid <= 1'b0;
    while (min_max_queue.size() != 0) @(posedge clk);
    repeat (WIN_DEPTH + 2) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_WINDOW_SIZE: cur_wsize = data[WS_W-1:0];
      CFG_VALID_UPPER: cur_upper = data;
      default: ;
    endcase
  endtask

  task automatic test_directed_extremes();
    logic signed [READING_W-1:0] seq [16];
    seq = '{16'sd1, 16'sd19199, 16'sd19200, 16'sd32767, 16'sd0, 16'sd100, 16'sd5000,
            16'sd3, 16'sh2AAA, 16'sh5555, -16'sd1, 16'sd500, 16'sd600, 16'sh8000,
            -16'sd1, 16'sh7FFF};
    foreach (seq[i]) send_reading(seq[i]);
    send_reading(16'shC3A5);
    settle_block();
  endtask

  task automatic test_valid_upper();
    write_cfg(CFG_VALID_UPPER, '0);
    send_reading(16'sd1);
    send_reading(16'sd32767);
    send_reading(16'sd0);
    send_reading(16'sd12345);
    send_reading(random_terminator());
    settle_block();
    write_cfg(CFG_VALID_UPPER, 15'd1);
    send_reading(16'sd1);
    send_reading(16'sd0);
    send_reading(16'sd2);
    send_reading(random_terminator());
    settle_block();
    write_cfg(CFG_VALID_UPPER, 15'h7FFF);
    send_reading(16'sd32766);
    send_reading(16'sd32767);
    send_reading(16'sd1);
    send_reading(16'sd16384);
    send_reading(random_terminator());
    settle_block();
  endtask

  task automatic test_window_sizes();
    logic [WS_W-1:0] sizes [7];
    sizes = '{7'd1, 7'd0, 7'd2, 7'd64, 7'd65, 7'd127, 7'd5};
    write_cfg(CFG_VALID_UPPER, VU_RESET);
    foreach (sizes[i]) begin
      write_cfg(CFG_WINDOW_SIZE, CFG_DAT_W'(sizes[i]));
      repeat (70) send_reading(random_reading());
      send_reading(random_terminator());
      settle_block();
    end
  endtask

  task automatic test_resize_midstream();
    write_cfg(CFG_WINDOW_SIZE, 15'd64);
    repeat (40) send_reading(random_reading());
    settle_block();
    write_cfg(CFG_WINDOW_SIZE, 15'd3);
    repeat (10) send_reading(random_reading());
    settle_block();
    write_cfg(CFG_WINDOW_SIZE, 15'd127);
    repeat (10) send_reading(random_reading());
    send_reading(random_terminator());
    settle_block();
  endtask

  task automatic test_backpressure();
    write_cfg(CFG_WINDOW_SIZE, 15'd4);
    set_idling(1'b1);
    hold_toggle = ~hold_toggle;
    repeat (150) send_reading(random_reading());
    send_reading(random_terminator());
    settle_block();
  endtask

  task automatic test_random_streams();
    int              sent;
    int              len;
    int              pick;
    logic [WS_W-1:0] ws;
    logic [VAL_W-1:0] vu;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 2) == 0) begin
        settle_block();
        pick = $urandom_range(0, 7);
        if (pick == 0) ws = '0;
        else if (pick == 1) ws = 7'd127;
        else if (pick == 2) ws = 7'd64;
        else ws = WS_W'($urandom_range(1, 16));
        write_cfg(CFG_WINDOW_SIZE, CFG_DAT_W'(ws));
        pick = $urandom_range(0, 9);
        if (pick == 0) vu = '0;
        else if (pick == 1) vu = 15'd1;
        else if (pick == 2) vu = 15'h7FFF;
        else vu = VAL_W'($urandom_range(1000, 32767));
        write_cfg(CFG_VALID_UPPER, vu);
      end
      set_idling((sent < RANDOM_ITEMS - QUIET_TAIL) && ($urandom_range(0, 3) != 0));
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 25);
      repeat (len) begin
        send_reading(random_reading());
        sent++;
      end
      send_reading(random_terminator());
      sent++;
    end
  endtask

  // receiver: random stall bursts, plus one long hold on request from the test
  initial begin
    int burst;
    int hold_left;
    burst     = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_toggle != hold_seen) begin
        hold_seen = hold_toggle;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (burst > 0) begin
        burst--;
        out_ready <= 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
        burst = $urandom_range(1, 10) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_results
    min_max_result_t want;
    min_max_result_t got;
    if (rst_n && out_valid && out_ready) begin
      got.status        = out_status;
      got.sample_number = out_sample_number;
      got.value         = out_value;
      got.window_min    = out_window_min;
      got.window_max    = out_window_max;
      got.any_ignored   = out_any_ignored;
      if (min_max_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: status=%0d num=%0d value=%0d min=%0d max=%0d ign=%0d",
                   got.status, got.sample_number, $signed(got.value), got.window_min,
                   got.window_max, got.any_ignored);
      end else begin
        want = min_max_queue.pop_front();
        if (got.status !== want.status || got.sample_number !== want.sample_number ||
            got.value !== want.value || got.window_min !== want.window_min ||
            got.window_max !== want.window_max || got.any_ignored !== want.any_ignored) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch exp: status=%0d num=%0d value=%0d min=%0d max=%0d ign=%0d",
                     want.status, want.sample_number, $signed(want.value), want.window_min,
                     want.window_max, want.any_ignored);
            $display("         got: status=%0d num=%0d value=%0d min=%0d max=%0d ign=%0d",
                     got.status, got.sample_number, $signed(got.value), got.window_min,
                     got.window_max, got.any_ignored);
          end
        end
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("watchdog: no request moved for %0d cycles", STALL_LIMIT);
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    clear_window();
    cur_wsize = WS_RESET;
    cur_upper = VU_RESET;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_extremes();
    test_valid_upper();
    test_window_sizes();
    test_resize_midstream();
    test_backpressure();
    test_random_streams();
    set_idling(1'b0);
    settle_block();
    if (mismatches == 0 && min_max_queue.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
